>>> rtl/idh_pkg.sv
// ============================================================================
// idh_pkg
// Shared constants and helpers for the image difference hash block
// ============================================================================
package idh_pkg;

    // frame geometry
    localparam int MAX_DIM  = 4096;
    localparam int MAX_SIDE = 8;
    localparam int DIM_W    = 13;   // frame size registers
    localparam int POS_W    = 12;   // source column / row position
    localparam int SIDE_W   = 4;    // hash grid side register
    localparam int GRID_W   = 4;    // grid column / row counters, 0..MAX_SIDE+1
    localparam int NCOLS    = MAX_SIDE + 1;
    localparam int MUL_W    = 17;   // position times grid size products
    localparam int SHIFT_W  = 6;    // bit offset of a grid row in the hash

    // luma
    localparam int LUMA_W      = 8;
    localparam int SUM_W       = 18;
    localparam int WEIGHT_R    = 299;
    localparam int WEIGHT_G    = 587;
    localparam int WEIGHT_B    = 114;
    // x / 1000 == (x * LUMA_RECIP) >> LUMA_SHIFT for every x below 2**SUM_W
    localparam int RECIP_W     = 19;
    localparam int LUMA_SHIFT  = 28;
    localparam logic [RECIP_W-1:0] LUMA_RECIP = RECIP_W'(268436);
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam int HASH_W = 64;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SIDE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_RED_BLUE = 2'd3;

    // size of zero reads as one, anything above the maximum as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    function automatic logic [SIDE_W-1:0] side_eff(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v == '0 || v > SIDE_W'(MAX_SIDE)) begin
            r = SIDE_W'(MAX_SIDE);
        end
        return r;
    endfunction

endpackage

>>> rtl/image_difference_hash.sv
// ============================================================================
// image_difference_hash
// Streams a frame's pixels and returns its 64-bit difference hash
// ============================================================================
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  s_       | s_valid / s_ready   | s_chan0..2 pixel bytes, s_frame_start
//  m_       | m_valid / m_ready   | m_hash_value, one per frame
//  cfg_     | cfg_wr_en           | cfg_wr_index, cfg_wr_data
//
//  one pixel per cycle sustained unless a waiting hash holds the pipeline;
//  the last pixel of a frame passes the weighted sum and reciprocal multiply
//  stages, then the grid update stage loads its hash into the output register
//  aresetn is synchronous: it clears the pipeline, frame counters and hash,
//  and loads width 1, height 1, side 8, no red/blue swap
//  s_ready drops only when a hash waits in the output register and the last
//  pixel of the following frame has reached the grid update stage
//
module image_difference_hash
    import idh_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_chan0,
    input  logic [7:0]           s_chan1,
    input  logic [7:0]           s_chan2,
    input  logic                 s_frame_start,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [HASH_W-1:0]    m_hash_value,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [DIM_W-1:0]     cfg_wr_data
);

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [DIM_W-1:0]  frame_width_reg;
    logic [DIM_W-1:0]  frame_height_reg;
    logic [SIDE_W-1:0] hash_side_reg;
    logic              swap_red_blue_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= DIM_W'(1);
            frame_height_reg  <= DIM_W'(1);
            hash_side_reg     <= SIDE_W'(MAX_SIDE);
            swap_red_blue_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_wr_data;
                CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_wr_data;
                CFG_HASH_SIDE:     hash_side_reg     <= cfg_wr_data[SIDE_W-1:0];
                CFG_SWAP_RED_BLUE: swap_red_blue_reg <= cfg_wr_data[0];
            endcase
        end
    end

    // effective sizes, new values act at once
    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [SIDE_W-1:0] n_eff;

    assign w_eff = clamp_dim(frame_width_reg);
    assign h_eff = clamp_dim(frame_height_reg);
    assign n_eff = side_eff(hash_side_reg);

    // ------------------------------------------------------------------------
    // pipeline flow control
    // ------------------------------------------------------------------------
    logic v1_reg;       // weighted sum stage holds a pixel
    logic v2_reg;       // luma stage holds a pixel
    logic m_valid_reg;
    logic emits;        // pixel in the luma stage closes its frame
    logic out_free;
    logic fire3;        // luma stage pixel updates the grid state this cycle
    logic en2;
    logic en1;

    assign out_free = !m_valid_reg || m_ready;
    assign fire3    = v2_reg && (!emits || out_free);
    assign en2      = !v2_reg || fire3;
    assign en1      = !v1_reg || en2;
    assign s_ready  = en1;

    // ------------------------------------------------------------------------
    // stage 1: weighted channel sum, red/blue order chosen here
    // ------------------------------------------------------------------------
    logic [7:0]       red;
    logic [7:0]       blue;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_reg;
    logic             fs1_reg;

    always_comb begin
        if (swap_red_blue_reg) begin
            red  = s_chan0;
            blue = s_chan2;
        end else begin
            red  = s_chan2;
            blue = s_chan0;
        end
        sum_next = SUM_W'(red)     * SUM_W'(WEIGHT_R)
                 + SUM_W'(s_chan1) * SUM_W'(WEIGHT_G)
                 + SUM_W'(blue)    * SUM_W'(WEIGHT_B);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && s_valid) begin
            sum_reg <= sum_next;
            fs1_reg <= s_frame_start;
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: divide by 1000 through a reciprocal multiply
    // ------------------------------------------------------------------------
    logic [PROD_W-1:0] luma_prod;
    logic [LUMA_W-1:0] luma_reg;
    logic              fs2_reg;

    assign luma_prod = PROD_W'(sum_reg) * PROD_W'(LUMA_RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            luma_reg <= luma_prod[LUMA_SHIFT +: LUMA_W];
            fs2_reg  <= fs1_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: grid sampling, compare and hash assembly
    // ------------------------------------------------------------------------
    logic [POS_W-1:0]    src_col_reg,  src_col_next;
    logic [POS_W-1:0]    src_row_reg,  src_row_next;
    logic [GRID_W-1:0]   grid_col_reg, grid_col_next;
    logic [GRID_W-1:0]   grid_row_reg, grid_row_next;
    logic [LUMA_W-1:0]   prev_luma_reg, prev_luma_next;
    logic [MAX_SIDE-1:0] row_bits_reg, row_bits_next;
    logic [HASH_W-1:0]   hash_acc_reg, hash_acc_next;

    // state as seen by this pixel, a frame start clears it first
    logic [POS_W-1:0]    col_c;
    logic [POS_W-1:0]    row_c;
    logic [GRID_W-1:0]   gc_c;
    logic [GRID_W-1:0]   gr_c;
    logic [LUMA_W-1:0]   prev_c;
    logic [MAX_SIDE-1:0] bits_c;
    logic [HASH_W-1:0]   hash_c;

    // grid column k hits source column c when c*(n+1) <= k*w < (c+1)*(n+1)
    logic [GRID_W:0]     n_plus1;
    logic [MUL_W-1:0]    c_lo;
    logic [MUL_W-1:0]    c_hi;
    logic [MUL_W-1:0]    kw;
    logic [NCOLS-1:0]    col_hit;
    logic [NCOLS-1:0]    col_take;     // grid columns sampled by this pixel
    logic [GRID_W-1:0]   gc_after;
    logic [MAX_SIDE-1:0] bits_after;
    logic [LUMA_W-1:0]   prev_after;

    // grid row j hits source row r when r*n <= j*h < (r+1)*n
    logic [MUL_W-1:0]    r_lo;
    logic [MUL_W-1:0]    r_hi;
    logic [MUL_W-1:0]    jh;
    logic [MAX_SIDE-1:0] row_hit;
    logic [MAX_SIDE-1:0] row_take;     // grid rows stored at this row end
    logic [GRID_W-1:0]   gr_after;
    logic [MAX_SIDE:0]   side_mask;
    logic [MAX_SIDE-1:0] bits_masked;
    logic [SHIFT_W-1:0]  row_ofs;
    logic [HASH_W-1:0]   hash_after;

    logic last_col;
    logic last_row;

    always_comb begin
        if (fs2_reg) begin
            col_c  = '0;
            row_c  = '0;
            gc_c   = '0;
            gr_c   = '0;
            prev_c = '0;
            bits_c = '0;
            hash_c = '0;
        end else begin
            col_c  = src_col_reg;
            row_c  = src_row_reg;
            gc_c   = grid_col_reg;
            gr_c   = grid_row_reg;
            prev_c = prev_luma_reg;
            bits_c = row_bits_reg;
            hash_c = hash_acc_reg;
        end

        // columns: the run of hits starting at the next grid column
        n_plus1 = {1'b0, n_eff} + (GRID_W+1)'(1);
        c_lo    = MUL_W'(col_c) * MUL_W'(n_plus1);
        c_hi    = c_lo + MUL_W'(n_plus1);
        for (int k = 0; k < NCOLS; k++) begin
            kw         = MUL_W'(k) * MUL_W'(w_eff);
            col_hit[k] = (GRID_W'(k) <= n_eff) && (kw >= c_lo) && (kw < c_hi);
        end
        col_take[0] = col_hit[0] && (gc_c == '0);
        for (int k = 1; k < NCOLS; k++) begin
            col_take[k] = col_hit[k] && ((gc_c == GRID_W'(k)) || col_take[k-1]);
        end

        gc_after   = gc_c;
        bits_after = bits_c;
        for (int k = 0; k < NCOLS; k++) begin
            if (col_take[k]) begin
                gc_after = GRID_W'(k + 1);
            end
        end
        // only the first sample of the run compares against an older one,
        // repeated samples compare equal
        for (int k = 1; k < NCOLS; k++) begin
            if (col_take[k] && (gc_c == GRID_W'(k)) && (prev_c > luma_reg)) begin
                bits_after[k-1] = 1'b1;
            end
        end
        prev_after = (|col_take) ? luma_reg : prev_c;

        last_col = {1'b0, col_c} >= (w_eff - DIM_W'(1));
        last_row = {1'b0, row_c} >= (h_eff - DIM_W'(1));

        // rows: the run of hits starting at the next grid row
        r_lo = MUL_W'(row_c) * MUL_W'(n_eff);
        r_hi = r_lo + MUL_W'(n_eff);
        for (int j = 0; j < MAX_SIDE; j++) begin
            jh         = MUL_W'(j) * MUL_W'(h_eff);
            row_hit[j] = (GRID_W'(j) < n_eff) && (jh >= r_lo) && (jh < r_hi);
        end
        row_take[0] = row_hit[0] && (gr_c == '0);
        for (int j = 1; j < MAX_SIDE; j++) begin
            row_take[j] = row_hit[j] && ((gr_c == GRID_W'(j)) || row_take[j-1]);
        end

        side_mask   = ((MAX_SIDE+1)'(1) << n_eff) - (MAX_SIDE+1)'(1);
        bits_masked = bits_after & side_mask[MAX_SIDE-1:0];
        gr_after    = gr_c;
        hash_after  = hash_c;
        for (int j = 0; j < MAX_SIDE; j++) begin
            row_ofs = SHIFT_W'(j * int'(n_eff));
            if (row_take[j]) begin
                gr_after   = GRID_W'(j + 1);
                hash_after = hash_after | (HASH_W'(bits_masked) << row_ofs);
            end
        end

        emits = last_col && last_row;

        // next state
        src_col_next   = src_col_reg;
        src_row_next   = src_row_reg;
        grid_col_next  = grid_col_reg;
        grid_row_next  = grid_row_reg;
        prev_luma_next = prev_luma_reg;
        row_bits_next  = row_bits_reg;
        hash_acc_next  = hash_acc_reg;
        if (fire3) begin
            priority if (!last_col) begin
                src_col_next   = col_c + POS_W'(1);
                src_row_next   = row_c;
                grid_col_next  = gc_after;
                grid_row_next  = gr_c;
                prev_luma_next = prev_after;
                row_bits_next  = bits_after;
                hash_acc_next  = hash_c;
            end else if (!last_row) begin
                src_col_next   = '0;
                src_row_next   = row_c + POS_W'(1);
                grid_col_next  = '0;
                grid_row_next  = gr_after;
                prev_luma_next = '0;
                row_bits_next  = '0;
                hash_acc_next  = hash_after;
            end else begin
                // frame done, next pixel opens a new frame
                src_col_next   = '0;
                src_row_next   = '0;
                grid_col_next  = '0;
                grid_row_next  = '0;
                prev_luma_next = '0;
                row_bits_next  = '0;
                hash_acc_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            grid_col_reg  <= '0;
            grid_row_reg  <= '0;
            prev_luma_reg <= '0;
            row_bits_reg  <= '0;
            hash_acc_reg  <= '0;
        end else begin
            src_col_reg   <= src_col_next;
            src_row_reg   <= src_row_next;
            grid_col_reg  <= grid_col_next;
            grid_row_reg  <= grid_row_next;
            prev_luma_reg <= prev_luma_next;
            row_bits_reg  <= row_bits_next;
            hash_acc_reg  <= hash_acc_next;
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    logic [HASH_W-1:0] m_hash_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire3 && emits) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire3 && emits) begin
            m_hash_reg <= hash_after;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

endmodule

>>> rtl/idh_checker.sv
// ============================================================================
// idh_checker
// Port-level checks for the image difference hash block
// ============================================================================
module idh_checker
    import idh_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [HASH_W-1:0] m_hash_value
);

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("hash valid after reset");

    // with no hash waiting nothing can hold the pipeline back
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a stalled hash transaction holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hash_value))
        else $error("hash changed or dropped while stalled");

    // a pixel waits only behind a hash that is itself waiting
    a_stall_behind_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid && !m_ready)
        else $error("pixel stalled with no hash waiting");

endmodule

bind image_difference_hash idh_checker u_idh_checker (.*);

>>> tb/sv/tb_image_difference_hash.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_image_difference_hash
// Self-checking testbench for the streaming difference hash block
// ============================================================================
//
// pixels are streamed on the s_ channel and every transaction is folded into
// a local hash predictor; each frame's finished hash is queued and compared
// with the hash seen on the m_ channel. a short directed table comes first,
// then random frame geometries, fill patterns and broken frames, with
// settings rewritten only while the block is drained
//
module tb_image_difference_hash;

    import idh_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 8;     // pipeline is three deep, leave margin
    localparam int LUMA_DIV     = 1000;
    localparam int REGIME_ITEMS = 510;   // random pixels per idling regime

    typedef enum {ROW_PIXEL, ROW_REG} row_kind_t;
    typedef enum {FILL_NOISE, FILL_FALL, FILL_RISE, FILL_ROWS, FILL_NEAR} fill_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [DIM_W-1:0]       val;
        logic [7:0]             c0;
        logic [7:0]             c1;
        logic [7:0]             c2;
        logic                   fs;
        bit                     typed;
        logic [HASH_W-1:0]      typed_hash;
    } dir_row_t;

    // ------------------------------------------------------------------------
    // dut hookup
    // ------------------------------------------------------------------------
    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_chan0       = '0;
    logic [7:0]           s_chan1       = '0;
    logic [7:0]           s_chan2       = '0;
    logic                 s_frame_start = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [HASH_W-1:0]    m_hash_value;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index  = '0;
    logic [DIM_W-1:0]     cfg_wr_data   = '0;

    image_difference_hash uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_chan0       (s_chan0),
        .s_chan1       (s_chan1),
        .s_chan2       (s_chan2),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hash_value  (m_hash_value),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // predictor state: settings as last written, frame position and hash
    // ------------------------------------------------------------------------
    logic [DIM_W-1:0]  reg_width;
    logic [DIM_W-1:0]  reg_height;
    logic [SIDE_W-1:0] reg_side;
    logic              reg_swap;

    logic [POS_W-1:0]  pos_col;      // source position of the next pixel
    logic [POS_W-1:0]  pos_row;
    logic [GRID_W-1:0] samp_col;     // next grid point still to be sampled
    logic [GRID_W-1:0] samp_row;
    logic [LUMA_W-1:0] last_luma;    // previous sample of this grid row
    logic [7:0]        cmp_bits;     // left-brighter-than-right bits of this row
    logic [HASH_W-1:0] hash_sofar;

    logic [HASH_W-1:0] pending_hashes[$];   // one entry per finished frame
    int                mismatch_count = 0;
    int                pixels_sent    = 0;
    int                in_idle_pct    = 0;
    int                out_idle_pct   = 0;
    dir_row_t          directed_rows[$];

    function automatic int eff_dim(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (v > DIM_W'(MAX_DIM)) begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    function automatic void clear_frame_state();
        pos_col    = '0;
        pos_row    = '0;
        samp_col   = '0;
        samp_row   = '0;
        last_luma  = '0;
        cmp_bits   = '0;
        hash_sofar = '0;
    endfunction

    // fold one accepted pixel into the running hash; flags the end of a frame
    function automatic void fold_pixel_into_hash(
        input  logic [7:0]        c0,
        input  logic [7:0]        c1,
        input  logic [7:0]        c2,
        input  logic              fs,
        output bit                frame_done,
        output logic [HASH_W-1:0] frame_hash
    );
        int                w;
        int                h;
        int                n;
        int                red;
        int                blue;
        logic [LUMA_W-1:0] lum;
        logic [7:0]        row_mask;

        frame_done = 1'b0;
        frame_hash = '0;
        w = eff_dim(reg_width);
        h = eff_dim(reg_height);
        n = (reg_side == '0 || reg_side > SIDE_W'(MAX_SIDE)) ? MAX_SIDE : int'(reg_side);

        // frame start wipes whatever partial frame was in flight
        if (fs) begin
            clear_frame_state();
        end

        red  = reg_swap ? int'(c0) : int'(c2);
        blue = reg_swap ? int'(c2) : int'(c0);
        lum  = LUMA_W'((red * WEIGHT_R + int'(c1) * WEIGHT_G + blue * WEIGHT_B) / LUMA_DIV);

        // one source column may serve several grid columns in a row
        while (int'(samp_col) <= n && (int'(samp_col) * w) / (n + 1) == int'(pos_col)) begin
            if (samp_col > 0 && last_luma > lum) begin
                cmp_bits[samp_col - 1] = 1'b1;
            end
            last_luma = lum;
            samp_col++;
        end

        // a position past a shrunken size counts as the last one
        if (int'(pos_col) < w - 1) begin
            pos_col++;
            return;
        end

        row_mask = 8'((1 << n) - 1);
        while (int'(samp_row) < n && (int'(samp_row) * h) / n == int'(pos_row)) begin
            hash_sofar |= HASH_W'(cmp_bits & row_mask) << (int'(samp_row) * n);
            samp_row++;
        end
        cmp_bits  = '0;
        last_luma = '0;
        samp_col  = '0;
        pos_col   = '0;

        if (int'(pos_row) < h - 1) begin
            pos_row++;
            return;
        end

        frame_done = 1'b1;
        frame_hash = hash_sofar;
        clear_frame_state();
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one pixel transaction; valid holds until s_ready takes it
    task automatic send_pixel(
        input  logic [7:0]        c0,
        input  logic [7:0]        c1,
        input  logic [7:0]        c2,
        input  logic              fs,
        input  bit                typed,
        input  logic [HASH_W-1:0] typed_hash,
        output bit                frame_done
    );
        logic [HASH_W-1:0] hv;

        while ($urandom_range(0, 99) < in_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_chan0       <= c0;
        s_chan1       <= c1;
        s_chan2       <= c2;
        s_frame_start <= fs;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        fold_pixel_into_hash(c0, c1, c2, fs, frame_done, hv);
        if (frame_done) begin
            pending_hashes.push_back(typed ? typed_hash : hv);
        end
        pixels_sent++;
    endtask

    // settings only change once every hash is out and the pipeline is empty
    task automatic wait_block_idle();
        s_valid <= 1'b0;
        while (pending_hashes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        case (idx)
            CFG_FRAME_WIDTH:   reg_width  = data;
            CFG_FRAME_HEIGHT:  reg_height = data;
            CFG_HASH_SIDE:     reg_side   = data[SIDE_W-1:0];
            CFG_SWAP_RED_BLUE: reg_swap   = data[0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly small sizes, now and then zero or a little beyond the usual range
    function automatic logic [DIM_W-1:0] pick_dim(input int top);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DIM_W'($urandom_range(top + 1, 2 * top));
            default: return DIM_W'($urandom_range(1, top));
        endcase
    endfunction

    // stream pixels until the frame closes, or stop early after cut pixels
    task automatic send_frame(input int cut, input int restart_pct);
        fill_t      fill;
        int         count;
        int         wc;
        int         g;
        bit         done;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       fs;

        fill  = fill_t'($urandom_range(0, 4));
        count = 0;
        done  = 1'b0;
        while (!done && (cut == 0 || count < cut)) begin
            wc = eff_dim(reg_width);
            g  = 255 - (int'(pos_col) * 255) / ((wc > 1) ? wc - 1 : 1);
            if (g < 0) begin
                g = 0;
            end
            c0 = 8'($urandom);
            c1 = 8'($urandom);
            c2 = 8'($urandom);
            case (fill)
                FILL_FALL: begin
                    c0 = 8'(g); c1 = 8'(g); c2 = 8'(g);
                end
                FILL_RISE: begin
                    c0 = 8'(255 - g); c1 = 8'(255 - g); c2 = 8'(255 - g);
                end
                FILL_ROWS: begin
                    c0 = 8'(int'(pos_row) * 37 + 11); c1 = c0; c2 = c0;
                end
                // near-equal colors so luma truncation decides the compares
                FILL_NEAR: begin
                    c0 = 8'(120 + $urandom_range(0, 3));
                    c1 = 8'(120 + $urandom_range(0, 3));
                    c2 = 8'(120 + $urandom_range(0, 3));
                end
                default: ;
            endcase
            // rare stray frame start mid-frame breaks the sequence
            fs = (count == 0) ? ($urandom_range(0, 99) < restart_pct)
                              : ($urandom_range(0, 149) == 0);
            send_pixel(c0, c1, c2, fs, 1'b0, '0, done);
            count++;
        end
    endtask

    task automatic random_phase();
        int frames;

        wait_block_idle();
        write_reg(CFG_FRAME_WIDTH, pick_dim(10));
        write_reg(CFG_FRAME_HEIGHT, pick_dim(8));
        write_reg(CFG_HASH_SIDE, {9'($urandom), 4'($urandom_range(0, 15))});
        write_reg(CFG_SWAP_RED_BLUE, {12'($urandom), 1'($urandom)});
        frames = $urandom_range(1, 3);
        repeat (frames - 1) send_frame(0, 85);
        // often leave the last frame open so the next settings land mid-frame
        send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0, 85);
    endtask

    function automatic dir_row_t px(
        input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
        input logic fs, input bit typed, input logic [HASH_W-1:0] typed_hash
    );
        dir_row_t r;
        r = '{ROW_PIXEL, '0, '0, c0, c1, c2, fs, typed, typed_hash};
        return r;
    endfunction

    function automatic dir_row_t wr(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        dir_row_t r;
        r = '{ROW_REG, idx, val, '0, '0, '0, 1'b0, 1'b0, '0};
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // directed table; a typed hash is given only where it is obvious
    // ------------------------------------------------------------------------
    initial begin
        // out of reset: 1x1 frames, every pixel closes a frame with hash zero
        directed_rows.push_back(px(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 64'h0));
        directed_rows.push_back(px(8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 64'h0));
        directed_rows.push_back(px(8'hff, 8'h00, 8'hff, 1'b1, 1'b1, 64'h0));
        // 2x1 with side 1: a single bit, set when the left pixel is brighter
        directed_rows.push_back(wr(CFG_FRAME_WIDTH, 13'd2));
        directed_rows.push_back(wr(CFG_HASH_SIDE,   13'd1));
        directed_rows.push_back(px(8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 64'h0));
        directed_rows.push_back(px(8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 64'h1));
        directed_rows.push_back(px(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 64'h0));
        directed_rows.push_back(px(8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 64'h0));
        // blue-only then red-only: red outweighs blue unless the bytes swap
        directed_rows.push_back(px(8'hff, 8'h00, 8'h00, 1'b1, 1'b0, 64'h0));
        directed_rows.push_back(px(8'h00, 8'h00, 8'hff, 1'b0, 1'b1, 64'h0));
        directed_rows.push_back(wr(CFG_SWAP_RED_BLUE, 13'd1));
        directed_rows.push_back(px(8'hff, 8'h00, 8'h00, 1'b1, 1'b0, 64'h0));
        directed_rows.push_back(px(8'h00, 8'h00, 8'hff, 1'b0, 1'b1, 64'h1));
        directed_rows.push_back(wr(CFG_SWAP_RED_BLUE, 13'd0));
        // zero sizes read as one, side zero reads as eight
        directed_rows.push_back(wr(CFG_FRAME_WIDTH,  13'd0));
        directed_rows.push_back(wr(CFG_FRAME_HEIGHT, 13'd0));
        directed_rows.push_back(wr(CFG_HASH_SIDE,    13'd0));
        directed_rows.push_back(px(8'h5a, 8'ha5, 8'h3c, 1'b0, 1'b1, 64'h0));
        // 3x2 at side 4: source columns and rows serve several grid points
        directed_rows.push_back(wr(CFG_FRAME_WIDTH,  13'd3));
        directed_rows.push_back(wr(CFG_FRAME_HEIGHT, 13'd2));
        directed_rows.push_back(wr(CFG_HASH_SIDE,    13'd4));
        directed_rows.push_back(px(8'h10, 8'h20, 8'h30, 1'b1, 1'b0, 64'h0));
        directed_rows.push_back(px(8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 64'h0));
        // frame start in the middle drops the partial frame
        directed_rows.push_back(px(8'hc8, 8'h10, 8'h40, 1'b1, 1'b0, 64'h0));
        directed_rows.push_back(px(8'h20, 8'hf0, 8'h08, 1'b0, 1'b0, 64'h0));
        directed_rows.push_back(px(8'h80, 8'h80, 8'h80, 1'b0, 1'b0, 64'h0));
        directed_rows.push_back(px(8'h00, 8'hff, 8'h00, 1'b0, 1'b0, 64'h0));
        directed_rows.push_back(px(8'hff, 8'h00, 8'hff, 1'b0, 1'b0, 64'h0));
        directed_rows.push_back(px(8'h40, 8'h40, 8'h40, 1'b0, 1'b0, 64'h0));
        // side raised to 15 (reads as 8) in the middle of a row
        directed_rows.push_back(px(8'h90, 8'h30, 8'he0, 1'b1, 1'b0, 64'h0));
        directed_rows.push_back(px(8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 64'h0));
        directed_rows.push_back(wr(CFG_HASH_SIDE, 13'd15));
        directed_rows.push_back(px(8'h11, 8'h22, 8'h33, 1'b0, 1'b0, 64'h0));
        directed_rows.push_back(px(8'hee, 8'h01, 8'h7f, 1'b0, 1'b0, 64'h0));
        directed_rows.push_back(px(8'h00, 8'h80, 8'hff, 1'b0, 1'b0, 64'h0));
        directed_rows.push_back(px(8'h33, 8'h33, 8'h33, 1'b0, 1'b0, 64'h0));
    end

    // ------------------------------------------------------------------------
    // result side: random backpressure, every hash transaction is checked
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [HASH_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_hashes.size() == 0) begin
                $display("%0t: hash with no frame pending: expected none, actual %h",
                         $time, m_hash_value);
                mismatch_count++;
            end else begin
                want = pending_hashes.pop_front();
                if (m_hash_value !== want) begin
                    $display("%0t: hash_value mismatch: expected %h, actual %h",
                             $time, want, m_hash_value);
                    mismatch_count++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int  start;
        bit  done;

        reg_width  = DIM_W'(1);
        reg_height = DIM_W'(1);
        reg_side   = SIDE_W'(MAX_SIDE);
        reg_swap   = 1'b0;
        clear_frame_state();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles a third of the time, receiver stalls most of it
        in_idle_pct  = 33;
        out_idle_pct = 63;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                wait_block_idle();
                write_reg(directed_rows[i].idx, directed_rows[i].val);
            end else begin
                send_pixel(directed_rows[i].c0, directed_rows[i].c1, directed_rows[i].c2,
                           directed_rows[i].fs, directed_rows[i].typed,
                           directed_rows[i].typed_hash, done);
            end
        end

        // widest frame: all-ones width clamps to the maximum, a single row;
        // start it, then cut the width so the current column ends the row
        wait_block_idle();
        write_reg(CFG_FRAME_WIDTH, '1);
        write_reg(CFG_FRAME_HEIGHT, DIM_W'(1));
        write_reg(CFG_HASH_SIDE, DIM_W'($urandom_range(1, 8)));
        send_frame($urandom_range(20, 60), 100);
        wait_block_idle();
        write_reg(CFG_FRAME_WIDTH, DIM_W'(4));
        send_frame(0, 0);

        start = pixels_sent;
        while (pixels_sent - start < REGIME_ITEMS) begin
            random_phase();
        end

        // now the receiver is the eager side
        in_idle_pct  = 63;
        out_idle_pct = 33;

        // tallest frame: start it, then cut the height so the current row ends it
        wait_block_idle();
        write_reg(CFG_FRAME_WIDTH, DIM_W'(2));
        write_reg(CFG_FRAME_HEIGHT, DIM_W'(MAX_DIM + 1));
        send_frame($urandom_range(20, 60), 100);
        wait_block_idle();
        write_reg(CFG_FRAME_HEIGHT, DIM_W'(3));
        send_frame(0, 0);

        start = pixels_sent;
        while (pixels_sent - start < REGIME_ITEMS) begin
            random_phase();
        end

        // back to back on both sides
        in_idle_pct  = 0;
        out_idle_pct = 0;
        start = pixels_sent;
        while (pixels_sent - start < REGIME_ITEMS) begin
            random_phase();
        end

        // drain every outstanding hash, then give stray results time to show
        wait_block_idle();
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog for a hung handshake
    initial begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
rtl/idh_pkg.sv
rtl/image_difference_hash.sv
rtl/idh_checker.sv
tb/sv/tb_image_difference_hash.sv
